/* hdl/cib_pkg.sv */
// Shared types and constants for the currency index builder.
// Used by cib_unit, cib_hist and currency_index_builder; depends on nothing.
`timescale 1ns / 1ps

package cib_pkg;

  localparam int STEP_BINS   = 256;
  localparam int BIN_W       = $clog2(STEP_BINS);
  localparam int MAX_SOURCES = 255;
  localparam int CNT_W       = 8;
  localparam int FRAC_W      = 24;
  localparam int IDX_W       = 40;
  localparam int ACC_W       = 48;
  localparam int VACC_W      = 40;
  localparam int QUANT_W     = 25;
  localparam int HCNT_W      = 32;
  localparam int HSUM_W      = HCNT_W + BIN_W;

  // shared unit operand widths
  localparam int DVD_W  = 56;
  localparam int DVS_W  = 32;
  localparam int MPL_W  = 48;
  localparam int MCND_W = IDX_W;
  localparam int PROD_W = MCND_W + MPL_W;

  localparam logic [QUANT_W-1:0] QUANT_RESET = 25'd168;
  localparam logic [IDX_W-1:0]   IDX_ONE     = 40'd16777216;
  localparam logic [IDX_W-1:0]   IDX_MAX     = {IDX_W{1'b1}};

  // change clamp bounds, held at the width of the raw ratio change
  localparam logic signed [57:0] RC_MAX = (58'sd1 <<< (ACC_W - 1)) - 58'sd1;
  localparam logic signed [57:0] RC_MIN = -(58'sd1 <<< (ACC_W - 1));

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } unit_op_t;

  typedef struct packed {
    logic             bump;
    logic             med;
    logic             bump_up;
    logic [BIN_W-1:0] bin;
  } hist_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] med_up;
    logic [8:0] med_dn;
  } hist_stat_t;

endpackage

/* hdl/currency_index_builder.sv */
// A source beat that does not close the bar uses one 56-step division of the shared unit;
// a closing beat uses up to four divisions and one 48-step multiply.
// A finish beat makes two passes over the 256 histogram bins.
// One beat is handled at a time, paced by the shared bit-serial arithmetic unit.
// Reset (rst, synchronous): index returns to 1.0, sums and extremes clear, and a
// clearing sweep over all 256 histogram bins runs while input is stalled.
`timescale 1ns / 1ps

module currency_index_builder (
  input  logic                clk,
  input  logic                rst,
  // configuration: step quantum
  input  logic                cfg_write,
  input  logic [24:0]         cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [31:0]         prior_price,
  input  logic [31:0]         current_price,
  input  logic [31:0]         pair_volume,
  input  logic                inverted,
  input  logic                last_source,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [39:0]         index_value,
  output logic [31:0]         volume_average,
  output logic [39:0]         previous_low,
  output logic [39:0]         previous_high,
  output logic [7:0]          median_up_step,
  output logic signed [8:0]   median_down_step,
  output logic [39:0]         largest_rise,
  output logic signed [40:0]  largest_fall
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATIO,
    S_ACCUM,
    S_CLOSE,
    S_AVG,
    S_VAVG,
    S_SCALE,
    S_DIFF,
    S_STEP,
    S_BUMP,
    S_MED,
    S_EMIT
  } state_t;

  state_t                             state;
  logic [cib_pkg::QUANT_W-1:0]        step_quantum;

  // latched beat fields
  logic                               lat_inv;
  logic                               lat_last;
  logic [31:0]                        lat_vol;

  // bar state
  logic signed [cib_pkg::ACC_W-1:0]   acc;
  logic [cib_pkg::VACC_W-1:0]         vacc;
  logic [cib_pkg::CNT_W-1:0]          cnt;
  logic [cib_pkg::IDX_W-1:0]          idx;
  logic signed [cib_pkg::IDX_W:0]     rise;
  logic signed [cib_pkg::IDX_W:0]     fall;

  // working registers
  logic signed [cib_pkg::ACC_W-1:0]   chg;
  logic signed [cib_pkg::ACC_W-1:0]   avg;
  logic [cib_pkg::IDX_W-1:0]          nxt;
  logic signed [cib_pkg::IDX_W:0]     diff;
  logic [31:0]                        res_vavg;
  logic [cib_pkg::IDX_W-1:0]          res_lo;
  logic [cib_pkg::IDX_W-1:0]          res_hi;

  // shared unit command
  logic                               u_start;
  cib_pkg::unit_op_t                  u_op;
  logic [cib_pkg::DVD_W-1:0]          u_a;
  logic [cib_pkg::MPL_W-1:0]          u_b;
  logic                               u_busy;
  logic                               u_done;
  logic [cib_pkg::PROD_W-1:0]         u_res;

  cib_pkg::hist_cmd_t                 hcmd;
  cib_pkg::hist_stat_t                hstat;

  // datapath around the shared unit
  logic signed [57:0]                 rc_raw;
  logic signed [57:0]                 rc_sgn;
  logic signed [cib_pkg::ACC_W-1:0]   rc_clamp;
  logic signed [cib_pkg::ACC_W:0]     acc_sum;
  logic signed [cib_pkg::ACC_W-1:0]   acc_next;
  logic [cib_pkg::VACC_W:0]           vsum;
  logic [cib_pkg::ACC_W-1:0]          acc_abs;
  logic [cib_pkg::ACC_W-1:0]          avg_q;
  logic signed [cib_pkg::ACC_W-1:0]   avg_next;
  logic signed [cib_pkg::ACC_W:0]     factor;
  logic [cib_pkg::IDX_W-1:0]          scaled;
  logic signed [cib_pkg::IDX_W:0]     diff_next;
  logic [cib_pkg::IDX_W:0]            diff_abs;
  logic [cib_pkg::QUANT_W-1:0]        quant;
  logic [cib_pkg::DVD_W-1:0]          step_mag;
  logic                               step_up;
  logic [cib_pkg::BIN_W-1:0]          step_bin;
  logic                               accept;
  logic                               out_free;

  assign accept   = in_valid && !in_stall;
  // a held result may leave in the same cycle as the next one is loaded
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || hstat.busy;

  always_comb begin
    // ratio change: floor(cur * 2^24 / prior) - 1.0, negated on inverted pairs
    rc_raw   = $signed({2'b0, u_res[cib_pkg::DVD_W-1:0]}) - 58'sd16777216;
    rc_sgn   = lat_inv ? -rc_raw : rc_raw;
    if (rc_sgn > cib_pkg::RC_MAX)      rc_clamp = cib_pkg::RC_MAX[cib_pkg::ACC_W-1:0];
    else if (rc_sgn < cib_pkg::RC_MIN) rc_clamp = cib_pkg::RC_MIN[cib_pkg::ACC_W-1:0];
    else                               rc_clamp = rc_sgn[cib_pkg::ACC_W-1:0];

    // saturating change sum
    acc_sum = {acc[cib_pkg::ACC_W-1], acc} + {chg[cib_pkg::ACC_W-1], chg};
    if (acc_sum[cib_pkg::ACC_W] != acc_sum[cib_pkg::ACC_W-1])
      acc_next = acc_sum[cib_pkg::ACC_W] ? {1'b1, {(cib_pkg::ACC_W-1){1'b0}}}
                                         : {1'b0, {(cib_pkg::ACC_W-1){1'b1}}};
    else
      acc_next = acc_sum[cib_pkg::ACC_W-1:0];

    vsum = {1'b0, vacc} + {{(cib_pkg::VACC_W-31){1'b0}}, lat_vol};

    // mean change truncates toward zero: divide magnitudes, restore sign
    acc_abs  = acc[cib_pkg::ACC_W-1] ? -acc : acc;
    avg_q    = u_res[cib_pkg::ACC_W-1:0];
    avg_next = acc[cib_pkg::ACC_W-1] ? -avg_q : avg_q;
    factor   = {avg[cib_pkg::ACC_W-1], avg} + 49'sd16777216;

    scaled = (u_res[cib_pkg::PROD_W-1:cib_pkg::IDX_W+cib_pkg::FRAC_W] != '0)
           ? cib_pkg::IDX_MAX
           : u_res[cib_pkg::IDX_W+cib_pkg::FRAC_W-1:cib_pkg::FRAC_W];

    diff_next = $signed({1'b0, nxt}) - $signed({1'b0, idx});
    diff_abs  = diff[cib_pkg::IDX_W] ? -diff : diff;
    quant     = (step_quantum == '0) ? cib_pkg::QUANT_W'(1) : step_quantum;

    // a fall smaller than one quantum truncates to step zero: up bin 0
    step_mag = u_res[cib_pkg::DVD_W-1:0];
    step_up  = !diff[cib_pkg::IDX_W] || (step_mag == '0);
    if (step_up)
      step_bin = (step_mag > cib_pkg::DVD_W'(cib_pkg::STEP_BINS - 1))
               ? {cib_pkg::BIN_W{1'b1}} : step_mag[cib_pkg::BIN_W-1:0];
    else
      step_bin = (step_mag > cib_pkg::DVD_W'(cib_pkg::STEP_BINS))
               ? {cib_pkg::BIN_W{1'b1}} : step_mag[cib_pkg::BIN_W-1:0] - 1'b1;
  end

  cib_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .start  (u_start),
    .op     (u_op),
    .opa    (u_a),
    .opb    (u_b),
    .busy   (u_busy),
    .done   (u_done),
    .result (u_res)
  );

  cib_hist u_hist (
    .clk  (clk),
    .rst  (rst),
    .cmd  (hcmd),
    .stat (hstat)
  );

  always_ff @(posedge clk) begin
    u_start   <= 1'b0;
    hcmd.bump <= 1'b0;
    hcmd.med  <= 1'b0;
    if (rst) begin
      state        <= S_IDLE;
      step_quantum <= cib_pkg::QUANT_RESET;
      acc          <= '0;
      vacc         <= '0;
      cnt          <= '0;
      idx          <= cib_pkg::IDX_ONE;
      rise         <= '0;
      fall         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) step_quantum <= cfg_data;
      // drop the held result once it has been taken
      if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lat_inv  <= inverted;
            lat_last <= last_source;
            lat_vol  <= pair_volume;
            if (kind) begin
              hcmd.med <= 1'b1;
              res_vavg <= '0;
              res_lo   <= '0;
              res_hi   <= '0;
              state    <= S_MED;
            end else if (cnt < cib_pkg::CNT_W'(cib_pkg::MAX_SOURCES)) begin
              if (prior_price != '0) begin
                u_start <= 1'b1;
                u_op    <= cib_pkg::OP_DIV;
                u_a     <= {current_price, 24'b0};
                u_b     <= {16'b0, prior_price};
                state   <= S_RATIO;
              end else begin
                chg   <= '0;
                state <= S_ACCUM;
              end
            end else if (last_source) begin
              // full bar: skip the sample, still close
              state <= S_CLOSE;
            end
          end
        end
        S_RATIO: begin
          if (u_done) begin
            chg   <= rc_clamp;
            state <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          acc   <= acc_next;
          vacc  <= vsum[cib_pkg::VACC_W] ? cib_pkg::IDX_MAX : vsum[cib_pkg::VACC_W-1:0];
          cnt   <= cnt + 1'b1;
          state <= lat_last ? S_CLOSE : S_IDLE;
        end
        S_CLOSE: begin
          u_start <= 1'b1;
          u_op    <= cib_pkg::OP_DIV;
          u_a     <= {8'b0, acc_abs};
          u_b     <= {40'b0, cnt};
          state   <= S_AVG;
        end
        S_AVG: begin
          if (u_done) begin
            avg     <= avg_next;
            u_start <= 1'b1;
            u_op    <= cib_pkg::OP_DIV;
            u_a     <= {16'b0, vacc};
            u_b     <= {40'b0, cnt};
            state   <= S_VAVG;
          end
        end
        S_VAVG: begin
          if (u_done) begin
            res_vavg <= u_res[31:0];
            if (factor[cib_pkg::ACC_W] || (factor == '0)) begin
              // non-positive scale factor collapses the index
              nxt   <= '0;
              state <= S_DIFF;
            end else begin
              u_start <= 1'b1;
              u_op    <= cib_pkg::OP_MUL;
              u_a     <= {16'b0, idx};
              u_b     <= factor[cib_pkg::ACC_W-1:0];
              state   <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          if (u_done) begin
            nxt   <= scaled;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff   <= diff_next;
          if (diff_next > rise) rise <= diff_next;
          if (diff_next < fall) fall <= diff_next;
          res_lo <= (idx < nxt) ? idx : nxt;
          res_hi <= (idx > nxt) ? idx : nxt;
          idx    <= nxt;
          acc    <= '0;
          vacc   <= '0;
          cnt    <= '0;
          state  <= S_STEP;
        end
        S_STEP: begin
          // launch quantising divide on the first cycle, then wait
          if (!u_busy && !u_done && !u_start) begin
            u_start <= 1'b1;
            u_op    <= cib_pkg::OP_DIV;
            u_a     <= {15'b0, diff_abs};
            u_b     <= {23'b0, quant};
          end
          if (u_done) begin
            hcmd.bump    <= 1'b1;
            hcmd.bump_up <= step_up;
            hcmd.bin     <= step_bin;
            state        <= S_BUMP;
          end
        end
        S_BUMP: begin
          if (hstat.done) state <= S_EMIT;
        end
        S_MED: begin
          if (hstat.done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            index_value      <= idx;
            volume_average   <= res_vavg;
            previous_low     <= res_lo;
            previous_high    <= res_hi;
            median_up_step   <= hstat.med_up;
            median_down_step <= $signed(hstat.med_dn);
            largest_rise     <= rise[cib_pkg::IDX_W-1:0];
            largest_fall     <= fall;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a finish or bar-closing beat always occupies the block on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind || last_source)) |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // a new result appears only out of the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("result raised outside the emit step");

  // the shared unit is never left running while the block is idle
  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!u_busy && !u_done))
    else $error("shared unit active while idle");

  // held sample count stays within the bar limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACCUM) |-> (cnt < cib_pkg::CNT_W'(cib_pkg::MAX_SOURCES)))
    else $error("sample accumulated into a full bar");
`endif

endmodule

/* hdl/cib_unit.sv */
// Shared iterative arithmetic unit: restoring divider and shift-add multiplier.
// One bit per cycle; depends on cib_pkg.
`timescale 1ns / 1ps

module cib_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  cib_pkg::unit_op_t              op,
  input  logic [cib_pkg::DVD_W-1:0]      opa,
  input  logic [cib_pkg::MPL_W-1:0]      opb,
  output logic                           busy,
  output logic                           done,
  output logic [cib_pkg::PROD_W-1:0]     result
);

  cib_pkg::unit_op_t                op_r;
  logic [5:0]                       ctr;
  logic [cib_pkg::PROD_W-1:0]       work;
  logic [cib_pkg::MCND_W-1:0]       opnd;
  logic [cib_pkg::DVS_W-1:0]        rem;

  logic [cib_pkg::MCND_W:0]         msum;
  logic [cib_pkg::DVS_W:0]          rem_sh;
  logic [cib_pkg::DVS_W:0]          rem_sub;
  logic                             ge;

  // multiply step: add multiplicand on the low bit, then shift right
  assign msum = {1'b0, work[cib_pkg::PROD_W-1:cib_pkg::MPL_W]}
              + (work[0] ? {1'b0, opnd} : '0);

  // divide step: bring down the next dividend bit and try a subtract
  assign rem_sh  = {rem, work[cib_pkg::DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, opnd[cib_pkg::DVS_W-1:0]};
  assign ge      = (rem_sh >= {1'b0, opnd[cib_pkg::DVS_W-1:0]});

  assign result = work;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      ctr  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      op_r <= op;
      rem  <= '0;
      if (op == cib_pkg::OP_MUL) begin
        work <= {{cib_pkg::MCND_W{1'b0}}, opb};
        opnd <= opa[cib_pkg::MCND_W-1:0];
        ctr  <= 6'(cib_pkg::MPL_W - 1);
      end else begin
        work <= {{(cib_pkg::PROD_W - cib_pkg::DVD_W){1'b0}}, opa};
        opnd <= {{(cib_pkg::MCND_W - cib_pkg::DVS_W){1'b0}}, opb[cib_pkg::DVS_W-1:0]};
        ctr  <= 6'(cib_pkg::DVD_W - 1);
      end
    end else if (busy) begin
      if (op_r == cib_pkg::OP_MUL) begin
        work <= {msum, work[cib_pkg::MPL_W-1:1]};
      end else begin
        rem  <= ge ? rem_sub[cib_pkg::DVS_W-1:0] : rem_sh[cib_pkg::DVS_W-1:0];
        work[cib_pkg::DVD_W-1:0] <= {work[cib_pkg::DVD_W-2:0], ge};
      end
      ctr <= ctr - 6'd1;
      if (ctr == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

/* hdl/cib_hist.sv */
// Up and down step histograms: clearing sweep, saturating bump, median walk.
// Holds both histogram memories and the held medians; depends on cib_pkg.
`timescale 1ns / 1ps

module cib_hist (
  input  logic                clk,
  input  logic                rst,
  input  cib_pkg::hist_cmd_t  cmd,
  output cib_pkg::hist_stat_t stat
);

  typedef enum logic [2:0] {
    H_CLEAR,
    H_IDLE,
    H_BUMP,
    H_SUM,
    H_WALK
  } hstate_t;

  hstate_t                        state;
  logic [cib_pkg::HCNT_W-1:0]     up_mem [cib_pkg::STEP_BINS];
  logic [cib_pkg::HCNT_W-1:0]     dn_mem [cib_pkg::STEP_BINS];
  logic [cib_pkg::HCNT_W-1:0]     rd_up;
  logic [cib_pkg::HCNT_W-1:0]     rd_dn;

  logic [cib_pkg::BIN_W:0]        ptr;
  logic                           dv;
  logic [cib_pkg::BIN_W-1:0]      didx;
  logic                           bump_up;
  logic [cib_pkg::BIN_W-1:0]      bin;
  logic [cib_pkg::HSUM_W-1:0]     tot_up;
  logic [cib_pkg::HSUM_W-1:0]     tot_dn;
  logic [cib_pkg::HSUM_W-1:0]     run_up;
  logic [cib_pkg::HSUM_W-1:0]     run_dn;
  logic                           fnd_up;
  logic                           fnd_dn;
  logic [7:0]                     med_up;
  logic [8:0]                     med_dn;
  logic                           done;

  logic [cib_pkg::BIN_W-1:0]      ra_up;
  logic [cib_pkg::BIN_W-1:0]      ra_dn;
  logic [cib_pkg::BIN_W-1:0]      wa;
  logic                           we_up;
  logic                           we_dn;
  logic [cib_pkg::HCNT_W-1:0]     wd_up;
  logic [cib_pkg::HCNT_W-1:0]     wd_dn;
  logic [cib_pkg::HSUM_W-1:0]     run_up_next;
  logic [cib_pkg::HSUM_W-1:0]     run_dn_next;
  logic [cib_pkg::BIN_W+8:0]      up_key;
  logic [cib_pkg::BIN_W+8:0]      dn_key;

  always_comb begin
    ra_up = (state == H_IDLE) ? cmd.bin : ptr[cib_pkg::BIN_W-1:0];
    if (state == H_IDLE)      ra_dn = cmd.bin;
    else if (state == H_WALK) ra_dn = ~ptr[cib_pkg::BIN_W-1:0];
    else                      ra_dn = ptr[cib_pkg::BIN_W-1:0];

    wa    = (state == H_CLEAR) ? ptr[cib_pkg::BIN_W-1:0] : bin;
    we_up = (state == H_CLEAR) || ((state == H_BUMP) && bump_up);
    we_dn = (state == H_CLEAR) || ((state == H_BUMP) && !bump_up);
    wd_up = '0;
    wd_dn = '0;
    if (state == H_BUMP) begin
      wd_up = (&rd_up) ? rd_up : rd_up + 1'b1;
      wd_dn = (&rd_dn) ? rd_dn : rd_dn + 1'b1;
    end

    run_up_next = run_up + {{cib_pkg::BIN_W{1'b0}}, rd_up};
    run_dn_next = run_dn + {{cib_pkg::BIN_W{1'b0}}, rd_dn};
    up_key      = {9'b0, didx};
    dn_key      = {9'b0, ~didx};
  end

  always_ff @(posedge clk) begin
    if (we_up) up_mem[wa] <= wd_up;
    if (we_dn) dn_mem[wa] <= wd_dn;
    rd_up <= up_mem[ra_up];
    rd_dn <= dn_mem[ra_dn];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state  <= H_CLEAR;
      ptr    <= '0;
      dv     <= 1'b0;
      med_up <= '0;
      med_dn <= '0;
    end else begin
      unique case (state)
        H_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (&ptr[cib_pkg::BIN_W-1:0]) begin
            ptr   <= '0;
            state <= H_IDLE;
          end
        end
        H_IDLE: begin
          ptr    <= '0;
          dv     <= 1'b0;
          tot_up <= '0;
          tot_dn <= '0;
          if (cmd.bump) begin
            bump_up <= cmd.bump_up;
            bin     <= cmd.bin;
            state   <= H_BUMP;
          end else if (cmd.med) begin
            state <= H_SUM;
          end
        end
        H_BUMP: begin
          done  <= 1'b1;
          state <= H_IDLE;
        end
        H_SUM: begin
          if (!ptr[cib_pkg::BIN_W]) ptr <= ptr + 1'b1;
          dv   <= !ptr[cib_pkg::BIN_W];
          didx <= ptr[cib_pkg::BIN_W-1:0];
          if (dv) begin
            tot_up <= tot_up + {{cib_pkg::BIN_W{1'b0}}, rd_up};
            tot_dn <= tot_dn + {{cib_pkg::BIN_W{1'b0}}, rd_dn};
          end
          if (ptr[cib_pkg::BIN_W] && !dv) begin
            ptr    <= '0;
            run_up <= '0;
            run_dn <= '0;
            fnd_up <= (tot_up == '0);
            fnd_dn <= (tot_dn == '0);
            state  <= H_WALK;
          end
        end
        H_WALK: begin
          if (!ptr[cib_pkg::BIN_W]) ptr <= ptr + 1'b1;
          dv   <= !ptr[cib_pkg::BIN_W];
          didx <= ptr[cib_pkg::BIN_W-1:0];
          if (dv) begin
            run_up <= run_up_next;
            run_dn <= run_dn_next;
            // upper median: first key whose running count passes half
            if (!fnd_up && (run_up_next > (tot_up >> 1))) begin
              fnd_up <= 1'b1;
              med_up <= (up_key > 255) ? 8'd255 : up_key[7:0];
            end
            if (!fnd_dn && (run_dn_next > (tot_dn >> 1))) begin
              fnd_dn <= 1'b1;
              med_dn <= (dn_key > 255) ? 9'h100 : ~{1'b0, dn_key[7:0]};
            end
          end
          if (ptr[cib_pkg::BIN_W] && !dv) begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  assign stat.busy   = (state != H_IDLE);
  assign stat.done   = done;
  assign stat.med_up = med_up;
  assign stat.med_dn = med_dn;

endmodule
